[hdl/iatc_pkg.sv]
// Shared types and constants for the IP address text classifier.
package iatc_pkg;

	// Default depth of the queue between the classifying front and the tracking back.
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	// Width of the input character and of the padded result word.
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned TDATA_OUT_W = 8;

	// Tracker limits.
	localparam int unsigned V4_GROUPS = 4;
	localparam int unsigned V6_GROUPS = 8;
	localparam int unsigned V4_MAX_DIGITS = 3;
	localparam int unsigned V6_MAX_DIGITS = 4;
	localparam int unsigned V4_LIMIT = 256;

	// Separator characters.
	localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

	// Result codes.
	typedef enum logic [1:0] {
		KIND_V4      = 2'd0,
		KIND_V6      = 2'd1,
		KIND_NEITHER = 2'd2
	} kind_t;

	// One classified character as it travels from the front to the back.
	typedef struct packed {
		logic       last;
		logic       is_dot;
		logic       is_colon;
		logic       is_digit;
		logic       is_hex;
		logic [3:0] digit;
	} item_t;

endpackage

[hdl/iatc_front.sv]
// Front part: accepts characters and classifies them into a registered item.
module iatc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_char,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output iatc_pkg::item_t    out_item
);

	logic            valid_s1;
	iatc_pkg::item_t item_s1;
	iatc_pkg::item_t item_c;
	logic            is_dec;
	logic            is_lower;
	logic            is_upper;

	always_comb begin
		is_dec   = (in_char >= 8'h30) && (in_char <= 8'h39);
		is_lower = (in_char >= 8'h61) && (in_char <= 8'h66);
		is_upper = (in_char >= 8'h41) && (in_char <= 8'h46);
		item_c.last     = in_last;
		item_c.is_dot   = (in_char == iatc_pkg::CHAR_DOT);
		item_c.is_colon = (in_char == iatc_pkg::CHAR_COLON);
		item_c.is_digit = is_dec;
		item_c.is_hex   = is_dec || is_lower || is_upper;
		item_c.digit    = in_char[3:0];
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

[hdl/iatc_queue.sv]
// Short first-in first-out queue of classified items between front and back.
module iatc_queue #(
	parameter int unsigned DEPTH = iatc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  iatc_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output iatc_pkg::item_t pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	iatc_pkg::item_t  entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[hdl/iatc_back.sv]
// Back part: runs the IPv4 and IPv6 trackers and holds the result register.
module iatc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  iatc_pkg::item_t      in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output iatc_pkg::kind_t      out_kind
);

	logic [2:0]      v4_groups_q;
	logic [2:0]      v4_digits_q;
	logic [9:0]      v4_value_q;
	logic            v4_lz_q;
	logic            v4_broken_q;
	logic [3:0]      v6_groups_q;
	logic [2:0]      v6_digits_q;
	logic            v6_broken_q;
	logic            out_valid_q;
	iatc_pkg::kind_t out_kind_q;

	logic [2:0]      v4_groups_d;
	logic [2:0]      v4_digits_d;
	logic [9:0]      v4_value_d;
	logic            v4_lz_d;
	logic            v4_broken_d;
	logic [3:0]      v6_groups_d;
	logic [2:0]      v6_digits_d;
	logic            v6_broken_d;
	logic            v4_bad_end;
	logic            v6_bad_end;
	logic [2:0]      v4_groups_end;
	logic [3:0]      v6_groups_end;
	iatc_pkg::kind_t kind_d;
	logic            slot_free;
	logic            take;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !in_item.last || slot_free;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;

	always_comb begin
		v4_groups_d = v4_groups_q;
		v4_digits_d = v4_digits_q;
		v4_value_d  = v4_value_q;
		v4_lz_d     = v4_lz_q;
		v4_broken_d = v4_broken_q;
		v6_groups_d = v6_groups_q;
		v6_digits_d = v6_digits_q;
		v6_broken_d = v6_broken_q;

		// IPv4 tracker: a dot closes the open group, a digit extends it.
		if (in_item.is_dot) begin
			if ((v4_digits_q == 3'd0) || (v4_digits_q > 3'(iatc_pkg::V4_MAX_DIGITS)) ||
			    (v4_value_q >= 10'(iatc_pkg::V4_LIMIT)) ||
			    (v4_lz_q && (v4_digits_q > 3'd1))) begin
				v4_broken_d = 1'b1;
			end
			v4_groups_d = (v4_groups_q == 3'd7) ? v4_groups_q : v4_groups_q + 3'd1;
			v4_digits_d = 3'd0;
			v4_value_d  = 10'd0;
			v4_lz_d     = 1'b0;
		end else if (in_item.is_digit) begin
			if ((v4_digits_q == 3'd0) && (in_item.digit == 4'd0)) begin
				v4_lz_d = 1'b1;
			end
			if (v4_digits_q < 3'(iatc_pkg::V4_MAX_DIGITS)) begin
				v4_value_d = {v4_value_q[6:0], 3'b000} + {v4_value_q[8:0], 1'b0} +
				             {6'd0, in_item.digit};
			end
			v4_digits_d = (v4_digits_q == 3'd7) ? v4_digits_q : v4_digits_q + 3'd1;
		end else begin
			v4_broken_d = 1'b1;
		end

		// IPv6 tracker: a colon closes the open group, a hex digit extends it.
		if (in_item.is_colon) begin
			if ((v6_digits_q == 3'd0) || (v6_digits_q > 3'(iatc_pkg::V6_MAX_DIGITS))) begin
				v6_broken_d = 1'b1;
			end
			v6_groups_d = (v6_groups_q == 4'd15) ? v6_groups_q : v6_groups_q + 4'd1;
			v6_digits_d = 3'd0;
		end else if (in_item.is_hex) begin
			v6_digits_d = (v6_digits_q == 3'd7) ? v6_digits_q : v6_digits_q + 3'd1;
		end else begin
			v6_broken_d = 1'b1;
		end

		// The end of the string closes both open groups once more.
		v4_bad_end = v4_broken_d || (v4_digits_d == 3'd0) ||
		             (v4_digits_d > 3'(iatc_pkg::V4_MAX_DIGITS)) ||
		             (v4_value_d >= 10'(iatc_pkg::V4_LIMIT)) ||
		             (v4_lz_d && (v4_digits_d > 3'd1));
		v6_bad_end = v6_broken_d || (v6_digits_d == 3'd0) ||
		             (v6_digits_d > 3'(iatc_pkg::V6_MAX_DIGITS));
		v4_groups_end = (v4_groups_d == 3'd7) ? v4_groups_d : v4_groups_d + 3'd1;
		v6_groups_end = (v6_groups_d == 4'd15) ? v6_groups_d : v6_groups_d + 4'd1;

		if (!v4_bad_end && (v4_groups_end == 3'(iatc_pkg::V4_GROUPS))) begin
			kind_d = iatc_pkg::KIND_V4;
		end else if (!v6_bad_end && (v6_groups_end == 4'(iatc_pkg::V6_GROUPS))) begin
			kind_d = iatc_pkg::KIND_V6;
		end else begin
			kind_d = iatc_pkg::KIND_NEITHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_groups_q <= '0;
			v4_digits_q <= '0;
			v4_value_q  <= '0;
			v4_lz_q     <= 1'b0;
			v4_broken_q <= 1'b0;
			v6_groups_q <= '0;
			v6_digits_q <= '0;
			v6_broken_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && in_item.last) begin
				v4_groups_q <= '0;
				v4_digits_q <= '0;
				v4_value_q  <= '0;
				v4_lz_q     <= 1'b0;
				v4_broken_q <= 1'b0;
				v6_groups_q <= '0;
				v6_digits_q <= '0;
				v6_broken_q <= 1'b0;
			end else if (take) begin
				v4_groups_q <= v4_groups_d;
				v4_digits_q <= v4_digits_d;
				v4_value_q  <= v4_value_d;
				v4_lz_q     <= v4_lz_d;
				v4_broken_q <= v4_broken_d;
				v6_groups_q <= v6_groups_d;
				v6_digits_q <= v6_digits_d;
				v6_broken_q <= v6_broken_d;
			end
			if (take && in_item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_item.last) begin
			out_kind_q <= kind_d;
		end
	end

endmodule

[hdl/ip_address_text_classifier_unit.sv]
// Top level of the IP address text classifier: front, queue and back joined together.
// Path: each character is registered in the front stage, then in a queue entry, and then
// updates the trackers; the last character of a string writes its verdict into the result
// register. Throughput: one character per cycle while no last character waits for the
// result register to be collected. Reset: arst_n low clears the front stage, the queue pointers,
// the trackers and the result valid flag at once; payload registers keep whatever they held.
module ip_address_text_classifier_unit #(
	parameter int unsigned QUEUE_DEPTH = iatc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream: one character per transaction.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [iatc_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] char_code
	input  logic                          s_axis_tlast,   // last_char
	// Result stream: one transaction per string, after its last character.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [iatc_pkg::TDATA_OUT_W-1:0] m_axis_tdata // [1:0] address_kind, [7:2] zero
);

	// The front classifies each character (dot, colon, decimal digit, hex digit) and registers
	// it; the queue lets the front keep taking characters while the back waits on a result
	// that has not yet been collected.
	logic            front_valid;
	logic            front_ready;
	iatc_pkg::item_t front_item;
	logic            back_valid;
	logic            back_ready;
	iatc_pkg::item_t back_item;
	iatc_pkg::kind_t kind;

	iatc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_char   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	iatc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	// The back updates both trackers for every character; on the last one it closes the open
	// groups, writes the verdict into the result register and clears its state. Only a
	// last character waits for a free result register, so other characters never stall.
	iatc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (back_valid),
		.in_ready  (back_ready),
		.in_item   (back_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (kind)
	);

	assign m_axis_tdata = {6'd0, kind};

endmodule
